@@ hdl/zst_pkg.sv @@
// Shared types, constants and codes for the score top-select block.
package zst_pkg;

  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned PlaysBits  = 40;
  localparam int unsigned PosW       = $clog2(MaxEntries + 1);
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned ScoreW     = PlaysBits + PosW;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned StatusW    = 3;

  typedef enum logic [CmdW-1:0] {
    CmdLoad    = 2'd0,
    CmdExtract = 2'd1,
    CmdClear   = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatLoaded   = 3'd0,
    StatSelected = 3'd1,
    StatEmpty    = 3'd2,
    StatFull     = 3'd3,
    StatCleared  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  // One table entry as it moves along the chain.
  typedef struct packed {
    logic              live;
    logic [PosW-1:0]   pos;
    logic [ScoreW-1:0] score;
  } entry_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic            shift;
    logic            clear;
    logic            kill;
    logic [PosW-1:0] kill_pos;
  } cell_ctl_t;

endpackage

@@ hdl/zipf_score_top_select.sv @@
// Top level of the score top-select block: command decode, cell chain, result register.
//
// The table is a chain of MaxEntries cells. A load multiplies the play count by the
// next 1-based position, shifts the new entry into the first cell and pushes every
// other entry one cell along; its result strobes on the cycle after the start
// transaction, and busy stays low, so loads and clears may issue every cycle. An
// extract rotates the whole chain once around while one comparator at the last cell
// keeps the best live score (ties go to the earlier position); a done state then drops
// the winner's live flag and registers the result, so an extract holds busy through
// the rotation and the done state, and its result strobes in the cycle busy falls.
// A clear drops every live flag at once. A load into a full table is dropped and
// reported as such. Every result is shown on result_valid_o for exactly one cycle;
// the receiver cannot stall it, so capture it then.
module zipf_score_top_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [zst_pkg::CmdW-1:0]      cmd_i,
  input  logic [zst_pkg::PlaysBits-1:0] plays_i,
  output logic                          result_valid_o,
  output logic [zst_pkg::StatusW-1:0]   status_o,
  output logic [zst_pkg::PosW-1:0]      position_o
);

  localparam int unsigned N = zst_pkg::MaxEntries;

  zst_pkg::state_e              state_q, state_d;
  logic [zst_pkg::IdxW-1:0]     cnt_q, cnt_d;
  logic [zst_pkg::PosW-1:0]     count_q, count_d;
  logic                         valid_q, valid_d;
  logic [zst_pkg::StatusW-1:0]  status_q, status_d;
  logic [zst_pkg::PosW-1:0]     pos_q, pos_d;

  zst_pkg::cell_ctl_t           ctl;
  logic                         load_sel;
  logic                         best_start, best_en;
  logic                         found;
  logic [zst_pkg::PosW-1:0]     best_pos;
  logic [zst_pkg::PosW-1:0]     next_pos;
  zst_pkg::entry_t              new_ent;
  zst_pkg::entry_t              ent [N];
  zst_pkg::entry_t              prev [N];

  // Score of a new entry: play count times its position, full width.
  assign next_pos      = count_q + zst_pkg::PosW'(1);
  assign new_ent.live  = 1'b1;
  assign new_ent.pos   = next_pos;
  assign new_ent.score = zst_pkg::ScoreW'(plays_i) * zst_pkg::ScoreW'(next_pos);

  // The first cell takes a new entry on load and the last cell's entry on rotation.
  assign prev[0] = load_sel ? new_ent : ent[N-1];

  for (genvar g = 0; g < N; g++) begin : g_chain
    if (g > 0) begin : g_link
      assign prev[g] = ent[g-1];
    end
    zst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev[g]),
      .ent_o  (ent[g])
    );
  end

  zst_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (best_start),
    .en_i       (best_en),
    .head_i     (ent[N-1]),
    .found_o    (found),
    .best_pos_o (best_pos)
  );

  assign busy = (state_q != zst_pkg::StIdle);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    valid_d      = 1'b0;
    status_d     = status_q;
    pos_d        = pos_q;
    ctl          = '0;
    ctl.kill_pos = best_pos;
    load_sel     = 1'b0;
    best_start   = 1'b0;
    best_en      = 1'b0;

    case (state_q)
      zst_pkg::StIdle: begin
        if (start) begin
          valid_d = 1'b1;
          case (cmd_i)
            zst_pkg::CmdLoad: begin
              if (count_q == zst_pkg::PosW'(N)) begin
                // Table full: drop the load, state unchanged.
                status_d = zst_pkg::StatFull;
                pos_d    = '0;
              end else begin
                ctl.shift = 1'b1;
                load_sel  = 1'b1;
                count_d   = next_pos;
                status_d  = zst_pkg::StatLoaded;
                pos_d     = next_pos;
              end
            end
            zst_pkg::CmdExtract: begin
              // No result yet: hold it until the rotation completes.
              valid_d    = 1'b0;
              state_d    = zst_pkg::StScan;
              cnt_d      = '0;
              best_start = 1'b1;
            end
            default: begin
              // Clear, also reached by the unused code with the high bit set.
              ctl.clear = 1'b1;
              count_d   = '0;
              status_d  = zst_pkg::StatCleared;
              pos_d     = '0;
            end
          endcase
        end
      end
      zst_pkg::StScan: begin
        best_en   = 1'b1;
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + zst_pkg::IdxW'(1);
        if (cnt_q == zst_pkg::IdxW'(N - 1)) begin
          state_d = zst_pkg::StDone;
        end
      end
      zst_pkg::StDone: begin
        // Chain is back in place: drop the winner and report it.
        valid_d = 1'b1;
        state_d = zst_pkg::StIdle;
        if (found) begin
          ctl.kill = 1'b1;
          status_d = zst_pkg::StatSelected;
          pos_d    = best_pos;
        end else begin
          status_d = zst_pkg::StatEmpty;
          pos_d    = '0;
        end
      end
      default: begin
        state_d = zst_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zst_pkg::StIdle;
      cnt_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;

endmodule

@@ hdl/zst_cell.sv @@
// One storage cell of the entry chain.
module zst_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zst_pkg::cell_ctl_t  ctl_i,
  input  zst_pkg::entry_t     prev_i,
  output zst_pkg::entry_t     ent_o
);

  logic                       live_q, live_d;
  logic [zst_pkg::PosW-1:0]   pos_q, pos_d;
  logic [zst_pkg::ScoreW-1:0] score_q, score_d;

  always_comb begin
    live_d  = live_q;
    pos_d   = pos_q;
    score_d = score_q;
    if (ctl_i.clear) begin
      live_d = 1'b0;
    end else if (ctl_i.shift) begin
      live_d  = prev_i.live;
      pos_d   = prev_i.pos;
      score_d = prev_i.score;
    end else if (ctl_i.kill && live_q && (pos_q == ctl_i.kill_pos)) begin
      live_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    score_q <= score_d;
  end

  assign ent_o.live  = live_q;
  assign ent_o.pos   = pos_q;
  assign ent_o.score = score_q;

endmodule

@@ hdl/zst_best.sv @@
// Running maximum tracker watching the head of the rotating chain.
module zst_best (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     en_i,
  input  zst_pkg::entry_t          head_i,
  output logic                     found_o,
  output logic [zst_pkg::PosW-1:0] best_pos_o
);

  logic                       found_q, found_d;
  logic [zst_pkg::ScoreW-1:0] score_q, score_d;
  logic [zst_pkg::PosW-1:0]   pos_q, pos_d;
  logic                       take;

  // Higher score wins; on a tie the earlier position wins.
  assign take = head_i.live &&
                (!found_q || (head_i.score > score_q) ||
                 ((head_i.score == score_q) && (head_i.pos < pos_q)));

  always_comb begin
    found_d = found_q;
    score_d = score_q;
    pos_d   = pos_q;
    if (start_i) begin
      found_d = 1'b0;
    end else if (en_i && take) begin
      found_d = 1'b1;
      score_d = head_i.score;
      pos_d   = head_i.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    pos_q   <= pos_d;
  end

  assign found_o    = found_q;
  assign best_pos_o = pos_q;

endmodule

@@ hdl/zst_checker.sv @@
// Port-level checks for the score top-select block, bound to the top level.
module zst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [zst_pkg::CmdW-1:0]      cmd_i,
  input logic                          result_valid_o,
  input logic [zst_pkg::StatusW-1:0]   status_o,
  input logic [zst_pkg::PosW-1:0]      position_o
);

  // An accepted extract keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == zst_pkg::CmdExtract)) |=> busy)
    else $error("extract transaction did not raise busy");

  // Load and clear transactions answer in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i != zst_pkg::CmdExtract)) |=> (result_valid_o && !busy))
    else $error("load or clear transaction gave no result");

  // Empty, full and cleared results carry no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ((status_o == zst_pkg::StatEmpty) ||
                        (status_o == zst_pkg::StatFull) ||
                        (status_o == zst_pkg::StatCleared))) |-> (position_o == '0))
    else $error("position nonzero on a positionless result");

  // Loaded and selected results name a real position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ((status_o == zst_pkg::StatLoaded) ||
                        (status_o == zst_pkg::StatSelected))) |-> (position_o != '0))
    else $error("zero position on a loaded or selected result");

endmodule

bind zipf_score_top_select zst_checker u_zst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .position_o     (position_o)
);
